// ===== src/cspk_pkg.sv =====
// ----------------------------------------------------------------------------
// cspk_pkg - shared types, constants and functions
// Register indexes, video modes, pixel spread tables, row count and the
// queue entry passed from the front end to the back end.
// ----------------------------------------------------------------------------
package cspk_pkg;

	// configuration register indexes
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 10;

	localparam logic [CFG_INDEX_W-1:0] CFG_VIDEO_MODE     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHARS_PER_LINE = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RASTER     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_START_HIGH     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_START_LOW      = 3'd5;

	// pixel packing modes
	typedef enum logic [1:0] {
		MODE_4BIT      = 2'd0,
		MODE_2BIT      = 2'd1,
		MODE_1BIT      = 2'd2,
		MODE_2BIT_PAIR = 2'd3
	} video_mode_t;

	// register reset values
	localparam video_mode_t  RST_VIDEO_MODE     = MODE_2BIT;
	localparam logic [7:0]   RST_CHARS_PER_LINE = 8'd40;
	localparam logic [9:0]   RST_IMAGE_HEIGHT   = 10'd200;
	localparam logic [2:0]   RST_MAX_RASTER     = 3'd7;
	localparam logic [5:0]   RST_START_HIGH     = 6'd48;
	localparam logic [7:0]   RST_START_LOW      = 8'd0;

	// address tracking marks at the start of a frame
	localparam logic [15:0] MARK_LOW_RESET  = 16'hFFFF;
	localparam logic [15:0] MARK_HIGH_RESET = 16'h0000;

	// reciprocals for the row count, exact for 10-bit heights
	localparam logic [11:0] RECIP_3 = 12'd683;   // >> 11
	localparam logic [11:0] RECIP_5 = 12'd1639;  // >> 13
	localparam logic [11:0] RECIP_7 = 12'd2341;  // >> 14

	localparam logic [7:0] ROWS_MAX = 8'd255;

	// front to back queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef logic [7:0][3:0] pixels_t;

	typedef struct packed {
		logic [15:0] address;
		logic [7:0]  data;
		logic        last;
	} queue_entry_t;

	// four-bit index spread over alternate bit positions
	function automatic logic [7:0] spread4(input logic [3:0] idx);
		logic [7:0] v;
		unique case (idx)
			4'd0:  v = 8'd0;
			4'd1:  v = 8'd64;
			4'd2:  v = 8'd4;
			4'd3:  v = 8'd68;
			4'd4:  v = 8'd16;
			4'd5:  v = 8'd80;
			4'd6:  v = 8'd20;
			4'd7:  v = 8'd84;
			4'd8:  v = 8'd1;
			4'd9:  v = 8'd65;
			4'd10: v = 8'd5;
			4'd11: v = 8'd69;
			4'd12: v = 8'd17;
			4'd13: v = 8'd81;
			4'd14: v = 8'd21;
			default: v = 8'd85;
		endcase
		return v;
	endfunction

	// two-bit index spread four positions apart
	function automatic logic [7:0] spread2(input logic [1:0] idx);
		logic [7:0] v;
		unique case (idx)
			2'd0: v = 8'd0;
			2'd1: v = 8'd16;
			2'd2: v = 8'd1;
			default: v = 8'd17;
		endcase
		return v;
	endfunction

	// pack the pixels of one screen byte in hardware bit order
	function automatic logic [7:0] pack_byte(input video_mode_t mode, input pixels_t p);
		logic [7:0] v;
		v = 8'd0;
		unique case (mode)
			MODE_4BIT: begin
				v = (spread4(p[0]) << 1) | spread4(p[1]);
			end
			MODE_2BIT: begin
				v = (spread2(p[0][1:0]) << 3) | (spread2(p[1][1:0]) << 2)
				  | (spread2(p[2][1:0]) << 1) | spread2(p[3][1:0]);
			end
			MODE_1BIT: begin
				for (int i = 0; i < 8; i++) begin
					v[7-i] = p[i][0];
				end
			end
			MODE_2BIT_PAIR: begin
				v = (spread2(p[0][1:0]) << 3) | (spread2(p[1][1:0]) << 2);
			end
		endcase
		return v;
	endfunction

	// character rows per frame: height over raster lines, 1 to 255
	function automatic logic [7:0] rows_per_frame(input logic [9:0] height,
	                                              input logic [2:0] max_raster);
		logic [21:0] prod3;
		logic [21:0] prod5;
		logic [21:0] prod7;
		logic [9:0]  q;
		logic [7:0]  r;
		prod3 = 22'(height) * 22'(RECIP_3);
		prod5 = 22'(height) * 22'(RECIP_5);
		prod7 = 22'(height) * 22'(RECIP_7);
		unique case (max_raster)
			3'd0: q = height;
			3'd1: q = height >> 1;
			3'd2: q = 10'(prod3 >> 11);
			3'd3: q = height >> 2;
			3'd4: q = 10'(prod5 >> 13);
			3'd5: q = 10'(prod3 >> 12);
			3'd6: q = 10'(prod7 >> 14);
			default: q = height >> 3;
		endcase
		if (q > 10'(ROWS_MAX)) begin
			r = ROWS_MAX;
		end else if (q == 10'd0) begin
			r = 8'd1;
		end else begin
			r = q[7:0];
		end
		return r;
	endfunction

endpackage

// ===== src/cspk_pixel_if.sv =====
// ----------------------------------------------------------------------------
// cspk_pixel_if - pixel input channel
// Valid/ready channel carrying the eight pixels of one screen byte.
// ----------------------------------------------------------------------------
interface cspk_pixel_if;
	logic       valid;
	logic       ready;
	logic [3:0] pixel_0;
	logic [3:0] pixel_1;
	logic [3:0] pixel_2;
	logic [3:0] pixel_3;
	logic [3:0] pixel_4;
	logic [3:0] pixel_5;
	logic [3:0] pixel_6;
	logic [3:0] pixel_7;

	modport source (
		output valid, pixel_0, pixel_1, pixel_2, pixel_3,
		       pixel_4, pixel_5, pixel_6, pixel_7,
		input  ready
	);
	modport sink (
		input  valid, pixel_0, pixel_1, pixel_2, pixel_3,
		       pixel_4, pixel_5, pixel_6, pixel_7,
		output ready
	);
endinterface

// ===== src/cspk_byte_if.sv =====
// ----------------------------------------------------------------------------
// cspk_byte_if - screen byte output channel
// Valid/ready channel carrying one addressed screen byte and frame marks.
// ----------------------------------------------------------------------------
interface cspk_byte_if;
	logic        valid;
	logic        ready;
	logic [15:0] address;
	logic [7:0]  data;
	logic        last;
	logic [15:0] lowest_address;
	logic [15:0] highest_address;
	logic [16:0] span;

	modport source (
		output valid, address, data, last, lowest_address, highest_address, span,
		input  ready
	);
	modport sink (
		input  valid, address, data, last, lowest_address, highest_address, span,
		output ready
	);
endinterface

// ===== src/cspk_front.sv =====
// ----------------------------------------------------------------------------
// cspk_front - scan counters, address generation and packing
// Holds the configuration registers and the CRTC scan counters, accepts a
// pixel transaction, forms its address and packed byte and pushes both.
// ----------------------------------------------------------------------------
module cspk_front
	import cspk_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	cspk_pixel_if.sink             pix,
	output logic                   push_valid,
	input  logic                   push_ready,
	output queue_entry_t           push_entry
);

	video_mode_t mode_q;
	logic [7:0]  cpl_q;
	logic [9:0]  height_q;
	logic [2:0]  max_raster_q;
	logic [5:0]  start_high_q;
	logic [7:0]  start_low_q;

	logic [7:0]  row_q;
	logic [2:0]  raster_q;
	logic [7:0]  col_q;
	logic        phase_q;

	logic        accept;
	logic [15:0] row_base;
	logic [15:0] ma;
	logic [15:0] addr;
	logic [7:0]  cols;
	logic [7:0]  rows;
	logic        col_end;
	logic        raster_end;
	logic        row_end;
	logic        is_last;
	pixels_t     pixels;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= RST_VIDEO_MODE;
			cpl_q        <= RST_CHARS_PER_LINE;
			height_q     <= RST_IMAGE_HEIGHT;
			max_raster_q <= RST_MAX_RASTER;
			start_high_q <= RST_START_HIGH;
			start_low_q  <= RST_START_LOW;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VIDEO_MODE:     mode_q       <= video_mode_t'(cfg_data[1:0]);
				CFG_CHARS_PER_LINE: cpl_q        <= cfg_data[7:0];
				CFG_IMAGE_HEIGHT:   height_q     <= cfg_data;
				CFG_MAX_RASTER:     max_raster_q <= cfg_data[2:0];
				CFG_START_HIGH:     start_high_q <= cfg_data[5:0];
				CFG_START_LOW:      start_low_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign pix.ready = push_ready;
	assign accept    = pix.valid && push_ready;

	// memory address of the current byte
	assign row_base = 16'(row_q) * 16'(cpl_q);
	assign ma       = row_base + 16'(col_q) + 16'({start_high_q, start_low_q});
	assign addr     = {ma[13:12], raster_q, ma[9:0], phase_q};

	// end-of-count detection, a counter past its bound counts as at its end
	assign cols       = (cpl_q == 8'd0) ? 8'd1 : cpl_q;
	assign rows       = rows_per_frame(height_q, max_raster_q);
	assign col_end    = ({1'b0, col_q} + 9'd1) >= {1'b0, cols};
	assign raster_end = raster_q >= max_raster_q;
	assign row_end    = ({1'b0, row_q} + 9'd1) >= {1'b0, rows};
	assign is_last    = phase_q && col_end && raster_end && row_end;

	assign pixels = {pix.pixel_7, pix.pixel_6, pix.pixel_5, pix.pixel_4,
	                 pix.pixel_3, pix.pixel_2, pix.pixel_1, pix.pixel_0};

	assign push_valid         = pix.valid;
	assign push_entry.address = addr;
	assign push_entry.data    = pack_byte(mode_q, pixels);
	assign push_entry.last    = is_last;

	// scan counters: byte phase, column, raster line, character row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			raster_q <= '0;
			col_q    <= '0;
			phase_q  <= 1'b0;
		end else if (accept) begin
			if (is_last) begin
				row_q    <= '0;
				raster_q <= '0;
				col_q    <= '0;
				phase_q  <= 1'b0;
			end else if (!phase_q) begin
				phase_q <= 1'b1;
			end else begin
				phase_q <= 1'b0;
				if (!col_end) begin
					col_q <= col_q + 8'd1;
				end else begin
					col_q <= '0;
					if (!raster_end) begin
						raster_q <= raster_q + 3'd1;
					end else begin
						raster_q <= '0;
						row_q    <= row_q + 8'd1;
					end
				end
			end
		end
	end

endmodule

// ===== src/cspk_queue.sv =====
// ----------------------------------------------------------------------------
// cspk_queue - short queue between front end and back end
// Small register queue so that the two sides stall independently.
// ----------------------------------------------------------------------------
module cspk_queue
	import cspk_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  queue_entry_t push_entry,
	output logic         pop_valid,
	input  logic         pop_ready,
	output queue_entry_t pop_entry
);

	queue_entry_t           entries [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   push_fire;
	logic                   pop_fire;

	assign push_ready = count_q != QUEUE_CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;
	assign pop_entry  = entries[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push_fire) begin
			entries[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// fill count stays within the queue depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QUEUE_CNT_W'(QUEUE_DEPTH))
		else $error("queue fill count beyond depth");

	// draining the only entry without a refill leaves the queue empty
	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_fire && !push_fire && count_q == QUEUE_CNT_W'(1)) |=> !pop_valid)
		else $error("queue not empty after draining last entry");

endmodule

// ===== src/cspk_back.sv =====
// ----------------------------------------------------------------------------
// cspk_back - address marks and output register
// Tracks the lowest and highest address of the frame and registers each
// screen byte with its marks and span for the output channel.
// ----------------------------------------------------------------------------
module cspk_back
	import cspk_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         pop_valid,
	output logic         pop_ready,
	input  queue_entry_t pop_entry,
	cspk_byte_if.source  res
);

	logic        out_valid_q;
	logic [15:0] address_q;
	logic [7:0]  data_q;
	logic        last_q;
	logic [15:0] lowest_q;
	logic [15:0] highest_q;
	logic [16:0] span_q;
	logic [15:0] low_mark_q;
	logic [15:0] high_mark_q;

	logic        pop_fire;
	logic [15:0] low_next;
	logic [15:0] high_next;

	assign pop_ready = !out_valid_q || res.ready;
	assign pop_fire  = pop_valid && pop_ready;

	// marks including this byte
	assign low_next  = (pop_entry.address < low_mark_q)  ? pop_entry.address : low_mark_q;
	assign high_next = (pop_entry.address > high_mark_q) ? pop_entry.address : high_mark_q;

	// frame marks, back to their start values after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_mark_q  <= MARK_LOW_RESET;
			high_mark_q <= MARK_HIGH_RESET;
		end else if (pop_fire) begin
			if (pop_entry.last) begin
				low_mark_q  <= MARK_LOW_RESET;
				high_mark_q <= MARK_HIGH_RESET;
			end else begin
				low_mark_q  <= low_next;
				high_mark_q <= high_next;
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_ready) begin
			out_valid_q <= pop_valid;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (pop_fire) begin
			address_q <= pop_entry.address;
			data_q    <= pop_entry.data;
			last_q    <= pop_entry.last;
			lowest_q  <= low_next;
			highest_q <= high_next;
			span_q    <= {1'b0, high_next} - {1'b0, low_next} + 17'd1;
		end
	end

	assign res.valid           = out_valid_q;
	assign res.address         = address_q;
	assign res.data            = data_q;
	assign res.last            = last_q;
	assign res.lowest_address  = lowest_q;
	assign res.highest_address = highest_q;
	assign res.span            = span_q;

	// a presented byte lies within its frame marks
	a_addr_in_marks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (lowest_q <= address_q && address_q <= highest_q))
		else $error("byte address outside frame marks");

	// the final byte of a frame restarts the marks
	a_marks_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_fire && pop_entry.last) |=>
			(low_mark_q == MARK_LOW_RESET && high_mark_q == MARK_HIGH_RESET))
		else $error("frame marks not restarted after final byte");

endmodule

// ===== src/crtc_screen_byte_packer_unit.sv =====
// ----------------------------------------------------------------------------
// crtc_screen_byte_packer_unit - CRTC screen byte packer
// Packs the pixels of each screen byte per video mode, forms its CRTC
// memory address from internal scan counters and tracks frame marks.
//
//   channel  direction  payload
//   pix      in         pixel_0 .. pixel_7, 4 bits each
//   res      out        address, data, last, lowest/highest_address, span
//   cfg      in         cfg_we, cfg_index, cfg_data (write only)
//
// One transaction per cycle sustained while the queue has room; each byte
// passes through the queue and the output register before it appears on res.
// The row count multiply and the address multiply-add sit in the front end.
// Reset restores the register defaults and restarts the scan; no clearing.
// A four-entry queue lets the output stall while pixels keep arriving.
// ----------------------------------------------------------------------------
module crtc_screen_byte_packer_unit
	import cspk_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	cspk_pixel_if.sink             pix,
	cspk_byte_if.source            res
);

	logic         push_valid;
	logic         push_ready;
	queue_entry_t push_entry;
	logic         pop_valid;
	logic         pop_ready;
	queue_entry_t pop_entry;

	// scan counters, address and packing
	cspk_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pix        (pix),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	// decoupling queue
	cspk_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	// frame marks and output register
	cspk_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.res       (res)
	);

endmodule

// ===== tb/cspk_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspk_frame_checker - screen byte prediction and comparison
// Follows register writes and pixel transactions, predicts each packed
// byte with its CRTC address and frame marks, and compares every byte
// transaction field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module cspk_frame_checker
	import cspk_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	cspk_pixel_if                  pix,
	cspk_byte_if                   res,
	output int                     fail_count,
	output int                     pending,
	output int                     bytes_checked,
	output int                     frames_ended
);

	typedef struct packed {
		logic [15:0] address;
		logic [7:0]  data;
		logic        last;
		logic [15:0] lowest_address;
		logic [15:0] highest_address;
		logic [16:0] span;
	} screen_byte_t;

	// shadow copy of the registers
	video_mode_t mode;
	logic [7:0]  chars_per_line;
	logic [9:0]  image_height;
	logic [2:0]  max_raster;
	logic [5:0]  start_high;
	logic [7:0]  start_low;

	// scan position and address marks of the current frame
	logic [7:0]  char_row;
	logic [2:0]  raster_line;
	logic [7:0]  char_column;
	logic        byte_phase;
	logic [15:0] low_mark;
	logic [15:0] high_mark;

	screen_byte_t expected_bytes[$];

	initial begin
		fail_count    = 0;
		pending       = 0;
		bytes_checked = 0;
		frames_ended  = 0;
	end

	task automatic report_mismatch(input string what, input logic [16:0] got,
	                               input logic [16:0] want);
		fail_count++;
		if (fail_count <= 40) begin
			$display("[%0t] byte %0d %s: got 0x%0h, expected 0x%0h",
			         $time, bytes_checked, what, got, want);
		end
	endtask

	task automatic clear_scan();
		char_row    = 8'd0;
		raster_line = 3'd0;
		char_column = 8'd0;
		byte_phase  = 1'b0;
		low_mark    = 16'hFFFF;
		high_mark   = 16'h0000;
	endtask

	// byte, address and marks for one pixel transaction, then advance the scan
	task automatic predict_screen_byte(input pixels_t px, output screen_byte_t sb);
		logic [31:0] ma;
		logic [31:0] cols;
		logic [31:0] rows;
		logic        col_end;
		logic        ras_end;
		logic        row_end;

		ma = (32'(char_row) * 32'(chars_per_line) + 32'(char_column)
		     + 32'(start_high) * 32'd256 + 32'(start_low)) & 32'hFFFF;
		sb.address = {ma[13:12], raster_line, ma[9:0], byte_phase};

		// hardware bit order per mode, leftmost pixel in the high bits
		case (mode)
			MODE_4BIT: begin
				sb.data = {px[0][0], px[1][0], px[0][2], px[1][2],
				           px[0][1], px[1][1], px[0][3], px[1][3]};
			end
			MODE_2BIT: begin
				sb.data = {px[0][0], px[1][0], px[2][0], px[3][0],
				           px[0][1], px[1][1], px[2][1], px[3][1]};
			end
			MODE_1BIT: begin
				sb.data = {px[0][0], px[1][0], px[2][0], px[3][0],
				           px[4][0], px[5][0], px[6][0], px[7][0]};
			end
			default: begin
				sb.data = {px[0][0], px[1][0], 2'b00, px[0][1], px[1][1], 2'b00};
			end
		endcase

		if (sb.address < low_mark) low_mark = sb.address;
		if (sb.address > high_mark) high_mark = sb.address;
		sb.lowest_address  = low_mark;
		sb.highest_address = high_mark;
		sb.span            = 17'(high_mark) - 17'(low_mark) + 17'd1;

		// a counter at or past its bound counts as being at its end
		cols = (chars_per_line == 8'd0) ? 32'd1 : 32'(chars_per_line);
		rows = 32'(image_height) / (32'(max_raster) + 32'd1);
		if (rows > 32'd255) rows = 32'd255;
		if (rows == 32'd0) rows = 32'd1;
		col_end = (32'(char_column) + 32'd1) >= cols;
		ras_end = raster_line >= max_raster;
		row_end = (32'(char_row) + 32'd1) >= rows;
		sb.last = byte_phase && col_end && ras_end && row_end;

		if (sb.last) begin
			clear_scan();
		end else if (!byte_phase) begin
			byte_phase = 1'b1;
		end else begin
			byte_phase = 1'b0;
			if (!col_end) begin
				char_column++;
			end else begin
				char_column = 8'd0;
				if (!ras_end) begin
					raster_line++;
				end else begin
					raster_line = 3'd0;
					char_row++;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		screen_byte_t seen;
		screen_byte_t want;
		if (!arst_n) begin
			mode           = RST_VIDEO_MODE;
			chars_per_line = RST_CHARS_PER_LINE;
			image_height   = RST_IMAGE_HEIGHT;
			max_raster     = RST_MAX_RASTER;
			start_high     = RST_START_HIGH;
			start_low      = RST_START_LOW;
			clear_scan();
			expected_bytes.delete();
			pending = 0;
		end else begin
			// byte transaction against the oldest prediction
			if (res.valid && res.ready) begin
				seen = '{res.address, res.data, res.last, res.lowest_address,
				         res.highest_address, res.span};
				if (expected_bytes.size() == 0) begin
					report_mismatch("byte with nothing outstanding, address",
					                17'(seen.address), 17'd0);
				end else begin
					want = expected_bytes.pop_front();
					if (seen.address !== want.address)
						report_mismatch("address", 17'(seen.address), 17'(want.address));
					if (seen.data !== want.data)
						report_mismatch("data", 17'(seen.data), 17'(want.data));
					if (seen.last !== want.last)
						report_mismatch("last", 17'(seen.last), 17'(want.last));
					if (seen.lowest_address !== want.lowest_address)
						report_mismatch("lowest_address", 17'(seen.lowest_address),
						                17'(want.lowest_address));
					if (seen.highest_address !== want.highest_address)
						report_mismatch("highest_address", 17'(seen.highest_address),
						                17'(want.highest_address));
					if (seen.span !== want.span)
						report_mismatch("span", seen.span, want.span);
					if (want.last) frames_ended++;
				end
				bytes_checked++;
			end

			// register write, value masked to the register width
			if (cfg_we) begin
				case (cfg_index)
					CFG_VIDEO_MODE:     mode = video_mode_t'(cfg_data[1:0]);
					CFG_CHARS_PER_LINE: chars_per_line = cfg_data[7:0];
					CFG_IMAGE_HEIGHT:   image_height = cfg_data[9:0];
					CFG_MAX_RASTER:     max_raster = cfg_data[2:0];
					CFG_START_HIGH:     start_high = cfg_data[5:0];
					CFG_START_LOW:      start_low = cfg_data[7:0];
					default: ;
				endcase
			end

			// pixel transaction
			if (pix.valid && pix.ready) begin
				predict_screen_byte({pix.pixel_7, pix.pixel_6, pix.pixel_5, pix.pixel_4,
				                     pix.pixel_3, pix.pixel_2, pix.pixel_1, pix.pixel_0},
				                    want);
				expected_bytes.push_back(want);
			end
			pending = expected_bytes.size();
		end
	end

endmodule

// ===== tb/tb_crtc_screen_byte_packer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crtc_screen_byte_packer_unit - screen byte packer regression
// Directed bytes in every mode at extreme addresses, then random pixel
// bursts over many register settings with random output stalls and long
// output hold-offs; the frame checker predicts and compares each byte.
// ----------------------------------------------------------------------------
module tb_crtc_screen_byte_packer_unit
	import cspk_pkg::*;
();

	localparam int STALL_LIMIT     = 2000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int ITEM_TARGET     = 1400;

	// first index past the register list
	localparam logic [CFG_INDEX_W-1:0] CFG_NO_REG = 3'd6;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int fail_count;
	int pending;
	int bytes_checked;
	int frames_ended;
	int items_sent  = 0;
	int phase_count = 0;
	int burst_left  = 0;
	int hold_req    = 0;
	int hold_served = 0;
	int idle_cycles = 0;

	cspk_pixel_if pix_ch ();
	cspk_byte_if  res_ch ();

	crtc_screen_byte_packer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix       (pix_ch),
		.res       (res_ch)
	);

	cspk_frame_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pix           (pix_ch),
		.res           (res_ch),
		.fail_count    (fail_count),
		.pending       (pending),
		.bytes_checked (bytes_checked),
		.frames_ended  (frames_ended)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// offer one pixel transaction and hold it until accepted
	task automatic send_pixels(input pixels_t px);
		logic taken;
		pix_ch.valid   <= 1'b1;
		pix_ch.pixel_0 <= px[0];
		pix_ch.pixel_1 <= px[1];
		pix_ch.pixel_2 <= px[2];
		pix_ch.pixel_3 <= px[3];
		pix_ch.pixel_4 <= px[4];
		pix_ch.pixel_5 <= px[5];
		pix_ch.pixel_6 <= px[6];
		pix_ch.pixel_7 <= px[7];
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = pix_ch.ready;
			@(posedge clk);
		end
		items_sent++;
	endtask

	// random pixels in bursts with random gaps between them
	task automatic send_run(input int count);
		int gap;
		for (int i = 0; i < count; i++) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap > 0) begin
					pix_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
				                                         : $urandom_range(1, 16);
			end
			send_pixels(pixels_t'($urandom));
			burst_left--;
		end
	endtask

	// stop offering until every outstanding byte has come out
	task automatic wait_drained();
		pix_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// output side: random stall styles, each held for a random window,
	// plus long hold-offs on request
	initial begin
		int style;
		int window;
		res_ch.ready <= 1'b0;
		style = 0;
		window = 0;
		@(posedge clk);
		forever begin
			if (hold_req != hold_served) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_served++;
			end else begin
				if (window == 0) begin
					style = $urandom_range(0, 3);
					window = $urandom_range(16, 96);
				end
				window--;
				case (style)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= ($urandom_range(0, 3) != 0);
					2: res_ch.ready <= ($urandom_range(0, 9) < 3);
					default: res_ch.ready <= ((window % 3) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d bytes outstanding",
			         idle_cycles, pending);
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// stimulus
	initial begin
		video_mode_t dir_modes [4];
		pixels_t     dir_pixels [4];
		dir_modes  = '{MODE_4BIT, MODE_2BIT, MODE_1BIT, MODE_2BIT_PAIR};
		dir_pixels = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hA5C3_3C5A};

		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_index      <= CFG_VIDEO_MODE;
		cfg_data       <= '0;
		pix_ch.valid   <= 1'b0;
		pix_ch.pixel_0 <= 4'd0;
		pix_ch.pixel_1 <= 4'd0;
		pix_ch.pixel_2 <= 4'd0;
		pix_ch.pixel_3 <= 4'd0;
		pix_ch.pixel_4 <= 4'd0;
		pix_ch.pixel_5 <= 4'd0;
		pix_ch.pixel_6 <= 4'd0;
		pix_ch.pixel_7 <= 4'd0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings
		send_pixels(dir_pixels[0]);
		send_pixels(dir_pixels[1]);

		// four-byte frames at the top of the address space, every mode
		wait_drained();
		write_reg(CFG_CHARS_PER_LINE, 10'd1);
		write_reg(CFG_IMAGE_HEIGHT, 10'd2);
		write_reg(CFG_MAX_RASTER, 10'd1);
		write_reg(CFG_START_HIGH, 10'd63);
		write_reg(CFG_START_LOW, 10'd255);
		foreach (dir_modes[m]) begin
			wait_drained();
			write_reg(CFG_VIDEO_MODE, 10'(dir_modes[m]));
			foreach (dir_pixels[k]) send_pixels(dir_pixels[k]);
		end

		// zero line length, too few lines for a row, masked values, unused index
		wait_drained();
		write_reg(CFG_CHARS_PER_LINE, 10'h300);
		write_reg(CFG_IMAGE_HEIGHT, 10'd3);
		write_reg(CFG_MAX_RASTER, 10'h3FF);
		write_reg(CFG_START_HIGH, 10'd0);
		write_reg(CFG_START_LOW, 10'd0);
		write_reg(CFG_NO_REG, 10'h3FF);
		repeat (4) send_pixels(pixels_t'($urandom));

		// random settings, mostly small frames so that frames wrap often
		while (items_sent < ITEM_TARGET) begin
			wait_drained();
			phase_count++;
			if (phase_count == 1) begin
				write_reg(CFG_VIDEO_MODE, 10'(MODE_1BIT));
				write_reg(CFG_CHARS_PER_LINE, 10'd255);
				write_reg(CFG_IMAGE_HEIGHT, 10'd1023);
				write_reg(CFG_MAX_RASTER, 10'd7);
				write_reg(CFG_START_HIGH, 10'd63);
				write_reg(CFG_START_LOW, 10'd255);
			end else if (phase_count == 2) begin
				write_reg(CFG_VIDEO_MODE, 10'(MODE_4BIT));
				write_reg(CFG_CHARS_PER_LINE, 10'd1);
				write_reg(CFG_IMAGE_HEIGHT, 10'd1);
				write_reg(CFG_MAX_RASTER, 10'd0);
				write_reg(CFG_START_HIGH, 10'd0);
				write_reg(CFG_START_LOW, 10'd0);
			end else begin
				// partial updates leave counters past new bounds mid-frame
				if ($urandom_range(0, 3) != 0)
					write_reg(CFG_VIDEO_MODE, 10'($urandom));
				if ($urandom_range(0, 3) != 0)
					write_reg(CFG_CHARS_PER_LINE, {2'($urandom),
					          ($urandom_range(0, 7) == 0) ? 8'($urandom)
					                                      : 8'($urandom_range(0, 4))});
				if ($urandom_range(0, 3) != 0)
					write_reg(CFG_IMAGE_HEIGHT, ($urandom_range(0, 7) == 0)
					          ? 10'($urandom) : 10'($urandom_range(0, 16)));
				if ($urandom_range(0, 3) != 0)
					write_reg(CFG_MAX_RASTER, 10'($urandom));
				if ($urandom_range(0, 3) != 0)
					write_reg(CFG_START_HIGH, 10'($urandom));
				if ($urandom_range(0, 3) != 0)
					write_reg(CFG_START_LOW, 10'($urandom));
				if ($urandom_range(0, 3) == 0)
					write_reg(CFG_NO_REG + 3'($urandom_range(0, 1)), 10'($urandom));
			end

			// long output hold-off while pixels keep coming
			if (phase_count % 9 == 4) begin
				hold_req <= hold_req + 1;
				for (int i = 0; i < 48; i++) send_pixels(pixels_t'($urandom));
			end else begin
				send_run($urandom_range(20, 60));
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Covered %0d pixel transactions, %0d screen bytes, %0d random settings,",
		         items_sent, bytes_checked, phase_count);
		$display("%0d frame ends, %0d long output hold-offs, %0d mismatches.",
		         frames_ended, hold_served, fail_count);
		if (fail_count == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
